// ===== hdl/cnms_pkg.sv =====
// Package for the cosine nearest-match search block.
// Holds payload structs, operation and result codes, register indexes,
// controller states and the command and status bundles. No dependencies.
package cnms_pkg;

   localparam int DIM_W   = 10;
   localparam int DIST_W  = 18;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 18;
   localparam int QUO_W   = 17;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_RSVD  = 2'd3;

   localparam logic [1:0] KIND_ROW   = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [CSR_AW-1:0] REG_EMBED_DIM     = 2'd0;
   localparam logic [CSR_AW-1:0] REG_USE_THRESHOLD = 2'd1;
   localparam logic [CSR_AW-1:0] REG_MAX_DISTANCE  = 2'd2;

   localparam logic [DIM_W-1:0]  DIM_RESET  = 10'd128;
   localparam logic [DIST_W-1:0] DIST_RESET = 18'd65536;
   localparam logic [DIST_W-1:0] DIST_MAX   = 18'd131072;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] element_value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic              accepted;
      logic              found;
      logic [7:0]        best_row;
      logic [DIST_W-1:0] distance;
      logic [8:0]        row_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FINISH, ST_SQRT, ST_NRD, ST_NLOAD, ST_NDIV, ST_NWR,
      ST_SROW, ST_SISSUE, ST_SD1, ST_SD2, ST_EVAL, ST_CMP, ST_QDONE, ST_EMIT
   } state_type;

   typedef struct packed {
      logic elem_take;
      logic clear;
      logic reject;
      logic sqrt_start;
      logic sqrt_step;
      logic buf_rd;
      logic div_load;
      logic div_step;
      logic norm_wr;
      logic idx_inc;
      logic row_commit;
      logic scan_init;
      logic row_start;
      logic scan_rd;
      logic dist_eval;
      logic best_upd;
      logic row_inc;
      logic query_done;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic vec_ok;
      logic kind_query;
      logic room;
      logic have_rows;
      logic sum_zero;
      logic sqrt_last;
      logic div_last;
      logic idx_last;
      logic row_last;
      logic out_free;
   } stat_type;

endpackage

// ===== hdl/cnms_ram.sv =====
// Generic simple dual-port RAM with registered read.
// One write port and one read port; no dependencies.
module cnms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/cnms_ctrl.sv =====
// Controller state machine for the cosine nearest-match search.
// Depends on cnms_pkg; drives the datapath by command and reads its status.
module cnms_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  cnms_pkg::req_type req_data,
   output logic              req_ready,
   input  cnms_pkg::stat_type stat,
   output cnms_pkg::cmd_type cmd
);
   import cnms_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_data.operation)
                  OP_LOAD, OP_QUERY: begin
                     cmd.elem_take = 1'b1;
                     if (req_data.last) state_in = ST_FINISH;
                  end
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = ST_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_FINISH: begin
            if (stat.vec_ok && (stat.kind_query ? stat.have_rows : stat.room)) begin
               cmd.sqrt_start = 1'b1;
               state_in       = ST_SQRT;
            end else begin
               cmd.reject = 1'b1;
               state_in   = ST_EMIT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (stat.sqrt_last) state_in = ST_NRD;
         end
         ST_NRD: begin
            cmd.buf_rd = 1'b1;
            state_in   = ST_NLOAD;
         end
         ST_NLOAD: begin
            cmd.div_load = 1'b1;
            state_in     = stat.sum_zero ? ST_NWR : ST_NDIV;
         end
         ST_NDIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_NWR;
         end
         ST_NWR: begin
            cmd.norm_wr = 1'b1;
            if (!stat.idx_last) begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_NRD;
            end else if (stat.kind_query) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SROW;
            end else begin
               cmd.row_commit = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_SROW: begin
            cmd.row_start = 1'b1;
            state_in      = ST_SISSUE;
         end
         ST_SISSUE: begin
            cmd.scan_rd = 1'b1;
            if (stat.idx_last) state_in = ST_SD1;
            else cmd.idx_inc = 1'b1;
         end
         ST_SD1: state_in = ST_SD2;
         ST_SD2: state_in = ST_EVAL;
         ST_EVAL: begin
            cmd.dist_eval = 1'b1;
            state_in      = ST_CMP;
         end
         ST_CMP: begin
            cmd.best_upd = 1'b1;
            if (stat.row_last) begin
               state_in = ST_QDONE;
            end else begin
               cmd.row_inc = 1'b1;
               state_in    = ST_SROW;
            end
         end
         ST_QDONE: begin
            cmd.query_done = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== hdl/cnms_dp.sv =====
// Datapath for the cosine nearest-match search: vector buffer, row table,
// square sum, square root and divider units, dot product and best-row search.
// Depends on cnms_pkg and cnms_ram; driven by cnms_ctrl.
module cnms_dp #(
   parameter int MAX_ROWS = 256,
   parameter int DIM_MAX  = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cnms_pkg::req_type           req_data,
   input  logic                        csr_we,
   input  logic [cnms_pkg::CSR_AW-1:0] csr_addr,
   input  logic [cnms_pkg::CSR_DW-1:0] csr_wdata,
   input  cnms_pkg::cmd_type           cmd,
   output cnms_pkg::stat_type          stat,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output cnms_pkg::rsp_type           rsp_data
);
   import cnms_pkg::*;

   localparam int IW    = $clog2(DIM_MAX);
   localparam int CW    = $clog2(DIM_MAX + 1);
   localparam int EW    = (CW > DIM_W) ? CW : DIM_W;
   localparam int RIW   = $clog2(MAX_ROWS);
   localparam int SRW   = $clog2(MAX_ROWS + 1);
   localparam int SW    = 31 + IW;
   localparam int VW    = SW + 16 + ((SW + 16) % 2);
   localparam int RW    = VW / 2;
   localparam int SQCW  = $clog2(RW);
   localparam int NW    = (RW > 40) ? RW + 1 : 41;
   localparam int DOTW  = 33 + IW;
   localparam int QCW   = $clog2(QUO_W);

   localparam logic signed [DOTW:0] ONE_Q30 = (DOTW + 1)'(1) <<< 30;

   logic [DIM_W-1:0]  dim_ff, dim_in;
   logic              thr_ff, thr_in;
   logic [DIST_W-1:0] maxd_ff, maxd_in;

   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic           kind_ff, kind_in;
   logic [SW-1:0]  sum_ff, sum_in;
   logic [SRW-1:0] stored_ff, stored_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [SRW-1:0] row_ff, row_in;

   logic [VW-1:0]   rad_ff, rad_in;
   logic [RW+1:0]   sqrem_ff, sqrem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [SQCW-1:0] sqcnt_ff, sqcnt_in;

   logic [QUO_W-1:0] dvn_ff, dvn_in;
   logic [RW+1:0]    dvrem_ff, dvrem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [QCW-1:0]   dvcnt_ff, dvcnt_in;
   logic             neg_ff, neg_in;
   logic [15:0]      raw_ff, raw_in;

   logic               rdv_ff, rdv_in;
   logic               prv_ff, prv_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [DOTW-1:0] dot_ff, dot_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [SRW-1:0]     bidx_ff, bidx_in;
   logic               match_ff, match_in;

   logic [1:0]        rkind_ff, rkind_in;
   logic              racc_ff, racc_in;
   logic              rfnd_ff, rfnd_in;
   logic [SRW-1:0]    rrow_ff, rrow_in;
   logic [DIST_W-1:0] rdist_ff, rdist_in;

   rsp_type rsp_ff, rsp_in;
   logic    rspv_ff, rspv_in;

   logic            buf_we, buf_re;
   logic [IW-1:0]   buf_wa;
   logic [15:0]     buf_wd, buf_q;
   logic            st_we;
   logic [RIW+IW-1:0] st_wa, st_ra;
   logic [15:0]     st_q;

   logic            sw_part;
   logic [CW-1:0]   eff_cnt;
   logic            eff_ovf;
   logic [SW-1:0]   eff_sum;
   logic            full;
   logic signed [31:0] sq;
   logic [RW+1:0]   sq_t, sq_trial;
   logic            sq_ge;
   logic [16:0]     mag;
   logic [NW-1:0]   nval;
   logic [NW+RW+1:0] next;
   logic [RW+1:0]   dv_t, dv_d;
   logic            dv_ge;
   logic [15:0]     norm_val;
   logic signed [DOTW:0] dd;
   logic [DOTW:0]   rnd;
   logic [DOTW-14:0] uq;
   logic [DIST_W-1:0] dist_c, lim;
   logic            upd;
   logic [RIW+7:0]  brow_w;
   logic [SRW+8:0]  cnt_w;

   cnms_ram #(.WIDTH(16), .DEPTH(DIM_MAX)) u_buf (
      .clock(clock), .wr_en(buf_we), .wr_addr(buf_wa), .wr_data(buf_wd),
      .rd_en(buf_re), .rd_addr(idx_ff[IW-1:0]), .rd_data(buf_q)
   );

   cnms_ram #(.WIDTH(16), .DEPTH(MAX_ROWS << IW)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(norm_val),
      .rd_en(cmd.scan_rd), .rd_addr(st_ra), .rd_data(st_q)
   );

   // element intake
   assign sw_part = ((count_ff != '0) || ovf_ff) && (kind_ff != req_data.operation[0]);
   assign eff_cnt = sw_part ? '0 : count_ff;
   assign eff_ovf = sw_part ? 1'b0 : ovf_ff;
   assign eff_sum = sw_part ? '0 : sum_ff;
   assign full    = (EW'(eff_cnt) >= EW'(dim_ff)) || (eff_cnt >= CW'(DIM_MAX));
   assign sq      = req_data.element_value * req_data.element_value;

   // square root step
   assign sq_t     = {sqrem_ff[RW-1:0], rad_ff[VW-1 -: 2]};
   assign sq_trial = {root_ff, 2'b01};
   assign sq_ge    = sq_t >= sq_trial;

   // divider load and step
   assign mag  = buf_q[15] ? (17'd0 - {buf_q[15], buf_q}) : {1'b0, buf_q};
   assign nval = (NW'(mag) << 24) + NW'(root_ff);
   assign next = {{(RW + 2){1'b0}}, nval} >> QUO_W;
   assign dv_t = {dvrem_ff[RW:0], dvn_ff[QUO_W-1]};
   assign dv_d = {1'b0, root_ff, 1'b0};
   assign dv_ge = dv_t >= dv_d;

   always_comb begin
      if (sum_ff == '0) begin
         norm_val = raw_ff;
      end else if (neg_ff) begin
         norm_val = (quo_ff >= 17'd32768) ? 16'h8000 : 16'(17'd0 - quo_ff);
      end else begin
         norm_val = (quo_ff >= 17'd32767) ? 16'h7FFF : quo_ff[15:0];
      end
   end

   // distance and match rule
   assign dd     = ONE_Q30 - (DOTW + 1)'(dot_ff);
   assign rnd    = $unsigned(dd) + (DOTW + 1)'(8192);
   assign uq     = rnd[DOTW:14];
   assign dist_c = (dd <= 0) ? '0 :
                   (uq > (DOTW - 13)'(DIST_MAX)) ? DIST_MAX : uq[DIST_W-1:0];
   assign lim    = (maxd_ff > DIST_MAX) ? DIST_MAX : maxd_ff;
   assign upd    = !(thr_ff && (dist_ff > lim)) && (!match_ff || (dist_ff < best_ff));

   assign buf_we = (cmd.elem_take && !full) || (cmd.norm_wr && kind_ff);
   assign buf_wa = cmd.elem_take ? eff_cnt[IW-1:0] : idx_ff[IW-1:0];
   assign buf_wd = cmd.elem_take ? req_data.element_value : norm_val;
   assign buf_re = cmd.buf_rd || cmd.scan_rd;
   assign st_we  = cmd.norm_wr && !kind_ff;
   assign st_wa  = {stored_ff[RIW-1:0], idx_ff[IW-1:0]};
   assign st_ra  = {row_ff[RIW-1:0], idx_ff[IW-1:0]};

   assign stat.vec_ok     = !ovf_ff && (EW'(count_ff) == EW'(dim_ff));
   assign stat.kind_query = kind_ff;
   assign stat.room       = stored_ff < SRW'(MAX_ROWS);
   assign stat.have_rows  = stored_ff != '0;
   assign stat.sum_zero   = sum_ff == '0;
   assign stat.sqrt_last  = sqcnt_ff == '0;
   assign stat.div_last   = dvcnt_ff == '0;
   assign stat.idx_last   = (idx_ff + 1'b1) == count_ff;
   assign stat.row_last   = (row_ff + 1'b1) == stored_ff;
   assign stat.out_free   = !rspv_ff || rsp_ready;

   assign brow_w = {8'd0, rrow_ff[RIW-1:0]};
   assign cnt_w  = {9'd0, stored_ff};

   always_comb begin
      dim_in = dim_ff;  thr_in = thr_ff;  maxd_in = maxd_ff;
      count_in = count_ff;  ovf_in = ovf_ff;  kind_in = kind_ff;  sum_in = sum_ff;
      stored_in = stored_ff;  idx_in = idx_ff;  row_in = row_ff;
      rad_in = rad_ff;  sqrem_in = sqrem_ff;  root_in = root_ff;  sqcnt_in = sqcnt_ff;
      dvn_in = dvn_ff;  dvrem_in = dvrem_ff;  quo_in = quo_ff;  dvcnt_in = dvcnt_ff;
      neg_in = neg_ff;  raw_in = raw_ff;
      rdv_in = cmd.scan_rd;  prv_in = rdv_ff;  prod_in = prod_ff;  dot_in = dot_ff;
      dist_in = dist_ff;  best_in = best_ff;  bidx_in = bidx_ff;  match_in = match_ff;
      rkind_in = rkind_ff;  racc_in = racc_ff;  rfnd_in = rfnd_ff;
      rrow_in = rrow_ff;  rdist_in = rdist_ff;
      rsp_in = rsp_ff;  rspv_in = rspv_ff && !rsp_ready;

      if (cmd.elem_take) begin
         kind_in = req_data.operation[0];
         if (full) begin
            ovf_in   = 1'b1;
            count_in = eff_cnt;
            sum_in   = eff_sum;
         end else begin
            ovf_in   = eff_ovf;
            count_in = eff_cnt + 1'b1;
            sum_in   = eff_sum + SW'($unsigned(sq));
         end
      end
      if (cmd.sqrt_start) begin
         rad_in   = VW'({sum_ff, 16'd0});
         sqrem_in = '0;
         root_in  = '0;
         sqcnt_in = SQCW'(RW - 1);
         idx_in   = '0;
      end
      if (cmd.sqrt_step) begin
         rad_in   = rad_ff << 2;
         sqrem_in = sq_ge ? (sq_t - sq_trial) : sq_t;
         root_in  = {root_ff[RW-2:0], sq_ge};
         sqcnt_in = sqcnt_ff - 1'b1;
      end
      if (cmd.div_load) begin
         raw_in   = buf_q;
         neg_in   = buf_q[15];
         dvn_in   = nval[QUO_W-1:0];
         dvrem_in = next[RW+1:0];
         quo_in   = '0;
         dvcnt_in = QCW'(QUO_W - 1);
      end
      if (cmd.div_step) begin
         dvn_in   = dvn_ff << 1;
         dvrem_in = dv_ge ? (dv_t - dv_d) : dv_t;
         quo_in   = {quo_ff[QUO_W-2:0], dv_ge};
         dvcnt_in = dvcnt_ff - 1'b1;
      end
      if (cmd.idx_inc) idx_in = idx_ff + 1'b1;
      if (cmd.scan_init) begin
         row_in = '0;  best_in = '0;  bidx_in = '0;  match_in = 1'b0;
      end
      if (cmd.row_start) begin
         idx_in = '0;
         dot_in = '0;
      end
      if (rdv_ff) prod_in = $signed(buf_q) * $signed(st_q);
      if (prv_ff) dot_in = dot_ff + DOTW'(prod_ff);
      if (cmd.dist_eval) dist_in = dist_c;
      if (cmd.best_upd && upd) begin
         match_in = 1'b1;
         best_in  = dist_ff;
         bidx_in  = row_ff;
      end
      if (cmd.row_inc) row_in = row_ff + 1'b1;

      if (cmd.clear || cmd.reject || cmd.row_commit || cmd.query_done) begin
         count_in = '0;  sum_in = '0;  ovf_in = 1'b0;
         racc_in  = !cmd.reject;
         rfnd_in  = 1'b0;  rrow_in = '0;  rdist_in = '0;
      end
      if (cmd.clear) begin
         stored_in = '0;
         rkind_in  = KIND_CLEAR;
      end
      if (cmd.reject) rkind_in = kind_ff ? KIND_QUERY : KIND_ROW;
      if (cmd.row_commit) begin
         stored_in = stored_ff + 1'b1;
         rkind_in  = KIND_ROW;
      end
      if (cmd.query_done) begin
         rkind_in = KIND_QUERY;
         rfnd_in  = match_ff;
         rrow_in  = bidx_ff;
         rdist_in = best_ff;
      end
      if (cmd.out_load) begin
         rsp_in.result_kind = rkind_ff;
         rsp_in.accepted    = racc_ff;
         rsp_in.found       = rfnd_ff;
         rsp_in.best_row    = brow_w[7:0];
         rsp_in.distance    = rdist_ff;
         rsp_in.row_count   = cnt_w[8:0];
         rspv_in            = 1'b1;
      end

      if (csr_we) begin
         unique case (csr_addr)
            REG_EMBED_DIM: begin
               dim_in    = csr_wdata[DIM_W-1:0];
               stored_in = '0;
               count_in  = '0;  sum_in = '0;  ovf_in = 1'b0;
            end
            REG_USE_THRESHOLD: thr_in  = csr_wdata[0];
            REG_MAX_DISTANCE:  maxd_in = csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff    <= DIM_RESET;
         thr_ff    <= 1'b1;
         maxd_ff   <= DIST_RESET;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         kind_ff   <= 1'b0;
         sum_ff    <= '0;
         stored_ff <= '0;
         rdv_ff    <= 1'b0;
         prv_ff    <= 1'b0;
         rspv_ff   <= 1'b0;
      end else begin
         dim_ff    <= dim_in;
         thr_ff    <= thr_in;
         maxd_ff   <= maxd_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         kind_ff   <= kind_in;
         sum_ff    <= sum_in;
         stored_ff <= stored_in;
         rdv_ff    <= rdv_in;
         prv_ff    <= prv_in;
         rspv_ff   <= rspv_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;    row_ff   <= row_in;
      rad_ff   <= rad_in;    sqrem_ff <= sqrem_in;
      root_ff  <= root_in;   sqcnt_ff <= sqcnt_in;
      dvn_ff   <= dvn_in;    dvrem_ff <= dvrem_in;
      quo_ff   <= quo_in;    dvcnt_ff <= dvcnt_in;
      neg_ff   <= neg_in;    raw_ff   <= raw_in;
      prod_ff  <= prod_in;   dot_ff   <= dot_in;
      dist_ff  <= dist_in;   best_ff  <= best_in;
      bidx_ff  <= bidx_in;   match_ff <= match_in;
      rkind_ff <= rkind_in;  racc_ff  <= racc_in;
      rfnd_ff  <= rfnd_in;   rrow_ff  <= rrow_in;
      rdist_ff <= rdist_in;  rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ===== hdl/cosine_nearest_match_search.sv =====
// Top level of the cosine nearest-match search block.
// Depends on cnms_pkg, cnms_ctrl, cnms_dp (which holds two cnms_ram).
//
//   channel  ports                              role
//   req      req_valid/req_ready/req_data       element, query element or clear in
//   rsp      rsp_valid/rsp_ready/rsp_data       one result per finished vector or clear
//   csr      csr_we/csr_addr/csr_wdata          register write, no wait
//
// An element that does not end a vector is taken in ST_IDLE. Ending a stored row
// runs the square root after its last element (RW square-root steps, 28 at
// DIM_MAX 512, (47 + log2 DIM_MAX)/2 rounded up), then sends its n elements through
// the 17-step divider, which an all-zero vector skips; a query adds a dot-product
// scan over all stored rows. A clear goes from ST_IDLE to ST_EMIT, a rejected vector's
// last element through ST_FINISH to ST_EMIT. Reset is synchronous and needs no clearing pass. The output
// register frees the input side while a result waits; the final output load
// stalls on rsp_ready.
module cosine_nearest_match_search #(
   parameter int MAX_ROWS = 256,
   parameter int DIM_MAX  = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  cnms_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output cnms_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [cnms_pkg::CSR_AW-1:0] csr_addr,
   input  logic [cnms_pkg::CSR_DW-1:0] csr_wdata
);
   import cnms_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cnms_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_data(req_data),
      .req_ready(req_ready), .stat(stat), .cmd(cmd)
   );

   cnms_dp #(.MAX_ROWS(MAX_ROWS), .DIM_MAX(DIM_MAX)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .cmd(cmd), .stat(stat),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule

// ===== tb/sv/cnms_checker.sv =====
`timescale 1ns / 100ps
// Result checker for cosine_nearest_match_search: watches the req, rsp and csr ports,
// predicts each result in fixed point and compares it field by field.
// Depends on cnms_pkg.
module cnms_checker #(
   parameter int MAX_ROWS = 256,
   parameter int DIM_MAX  = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  cnms_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  cnms_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [cnms_pkg::CSR_AW-1:0] csr_addr,
   input  logic [cnms_pkg::CSR_DW-1:0] csr_wdata,
   output int                          pending,
   output int                          errors,
   output int                          checked
);
   import cnms_pkg::*;

   logic [DIM_W-1:0]  embed_dim;
   logic              use_threshold;
   logic [DIST_W-1:0] max_distance;

   logic signed [15:0] table_rows [0:MAX_ROWS-1][0:DIM_MAX-1];
   logic signed [15:0] row_elems [0:DIM_MAX-1];
   logic signed [15:0] query_elems [0:DIM_MAX-1];
   longint unsigned    energy;
   int                 elem_count;
   bit                 too_long;
   int                 row_total;
   logic [1:0]         open_op;

   rsp_type expected_results [$];

   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] unit_elem(input logic signed [15:0] e,
                                                    input longint unsigned root);
      longint unsigned mag, q;
      if (root == 0) return e;
      mag = (e < 0) ? longint'(-int'(e)) : longint'(e);
      q = ((mag << 24) + root) / (2 * root);
      if (e < 0) return (q >= 32768) ? -16'sd32768 : 16'(-longint'(q));
      return (q >= 32767) ? 16'sd32767 : 16'(q);
   endfunction

   function automatic logic [DIST_W-1:0] row_distance(input int row, input int n);
      longint d, dot;
      longint unsigned u;
      dot = 0;
      for (int i = 0; i < n; i++)
         dot += longint'(query_elems[i]) * longint'(table_rows[row][i]);
      d = (longint'(1) << 30) - dot;
      if (d <= 0) return '0;
      u = (unsigned'(d) + 8192) >> 14;
      return (u > DIST_MAX) ? DIST_MAX : DIST_W'(u);
   endfunction

   task automatic drop_partial();
      energy = 0;
      elem_count = 0;
      too_long = 0;
   endtask

   task automatic predict(input req_type it);
      rsp_type r;
      longint unsigned root;
      logic [DIST_W-1:0] lim, d;
      bit vec_ok, hit;
      r = '0;
      if (it.operation == OP_RSVD) return;
      if (it.operation == OP_CLEAR) begin
         row_total = 0;
         drop_partial();
         r.result_kind = KIND_CLEAR;
         r.accepted = 1;
      end else begin
         if ((elem_count != 0 || too_long) && open_op != it.operation) drop_partial();
         open_op = it.operation;
         if (elem_count >= embed_dim || elem_count >= DIM_MAX) begin
            too_long = 1;
         end else begin
            if (it.operation == OP_LOAD) row_elems[elem_count] = it.element_value;
            else query_elems[elem_count] = it.element_value;
            energy += unsigned'(longint'(it.element_value) *
                                longint'(it.element_value));
            elem_count++;
         end
         if (!it.last) return;
         vec_ok = !too_long && elem_count == embed_dim;
         root = (energy == 0) ? 0 : isqrt(energy << 16);
         r.result_kind = (it.operation == OP_LOAD) ? KIND_ROW : KIND_QUERY;
         if (it.operation == OP_LOAD) begin
            if (vec_ok && row_total < MAX_ROWS) begin
               for (int i = 0; i < elem_count; i++)
                  table_rows[row_total][i] = unit_elem(row_elems[i], root);
               row_total++;
               r.accepted = 1;
            end
         end else if (vec_ok && row_total > 0) begin
            r.accepted = 1;
            for (int i = 0; i < elem_count; i++)
               query_elems[i] = unit_elem(query_elems[i], root);
            lim = (max_distance > DIST_MAX) ? DIST_MAX : max_distance;
            hit = 0;
            for (int row = 0; row < row_total; row++) begin
               d = row_distance(row, elem_count);
               if (use_threshold && d > lim) continue;
               if (!hit || d < r.distance) begin
                  hit = 1;
                  r.distance = d;
                  r.best_row = 8'(row);
               end
            end
            r.found = hit;
         end
         drop_partial();
      end
      r.row_count = 9'(row_total);
      expected_results.push_front(r);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         embed_dim = DIM_RESET;
         use_threshold = 1;
         max_distance = DIST_RESET;
         drop_partial();
         row_total = 0;
         open_op = OP_LOAD;
         expected_results.delete();
         errors = 0;
         checked = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_EMBED_DIM: begin
                  embed_dim = csr_wdata[DIM_W-1:0];
                  row_total = 0;
                  drop_partial();
               end
               REG_USE_THRESHOLD: use_threshold = csr_wdata[0];
               REG_MAX_DISTANCE: max_distance = csr_wdata[DIST_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict(req_data);
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected transfer on rsp: %p", rsp_data);
            end else begin
               e = expected_results.pop_back();
               if (e.result_kind !== rsp_data.result_kind || e.accepted !== rsp_data.accepted
                   || e.found !== rsp_data.found || e.best_row !== rsp_data.best_row
                   || e.distance !== rsp_data.distance
                   || e.row_count !== rsp_data.row_count) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %p actual %p", e, rsp_data);
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

// ===== tb/sv/cosine_nearest_match_search_tb.sv =====
`timescale 1ns / 100ps
// Top of the cosine_nearest_match_search testbench: clock, reset, stimulus and verdict.
// Depends on cnms_pkg, cosine_nearest_match_search and cnms_checker.
module cosine_nearest_match_search_tb;
   import cnms_pkg::*;

   localparam int MAX_ROWS = 256;
   localparam int DIM_MAX  = 512;
   localparam int CYCLE_LIMIT = 3000000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_we;
   logic [CSR_AW-1:0]   csr_addr;
   logic [CSR_DW-1:0]   csr_wdata;
   int                  pending, errors, checked;
   int                  sent;
   int                  cycles;
   bit                  burst;
   int                  dim;

   cosine_nearest_match_search #(.MAX_ROWS(MAX_ROWS), .DIM_MAX(DIM_MAX)) dut (.*);

   cnms_checker #(.MAX_ROWS(MAX_ROWS), .DIM_MAX(DIM_MAX)) checker_i (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int stall;
      rsp_ready = 0;
      forever begin
         stall = burst ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
      end
   end

   task automatic push(input logic [1:0] op, input logic signed [15:0] val, input logic last);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{operation: op, element_value: val, last: last};
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sent++;
   endtask

   function automatic logic signed [15:0] rand_elem(input int style);
      case (style)
         0: return 16'($urandom);
         1: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
         2: return 16'($urandom_range(0, 8)) - 16'sd4;
         default: return '0;
      endcase
   endfunction

   task automatic send_vector(input logic [1:0] op, input int n, input int style);
      for (int i = 0; i < n; i++) push(op, rand_elem(style), i == n - 1);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input int value);
      drain();
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= CSR_DW'(value);
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
      if (idx == REG_EMBED_DIM) dim = value & 10'h3FF;
   endtask

   task automatic random_phase(input int items, input int load_bias);
      int pick, n, stop;
      stop = sent + items;
      while (sent < stop) begin
         burst = ($urandom_range(0, 9) == 0);
         pick = $urandom_range(0, 99);
         n = (dim == 0 || dim > DIM_MAX) ? 1 : dim;
         if (pick < load_bias)
            send_vector(OP_LOAD, n, $urandom_range(0, 4));
         else if (pick < 85)
            send_vector(OP_QUERY, n, $urandom_range(0, 4));
         else if (pick < 89)
            send_vector(2'($urandom_range(0, 1)),
                        n + $urandom_range(0, 1) * 2 - 1 + (n == 1), 0);
         else if (pick < 93) begin
            send_vector(OP_LOAD, $urandom_range(1, n), 0);
            push(OP_QUERY, rand_elem(0), 0);
         end else if (pick < 97)
            push(OP_RSVD, rand_elem(0), 1'($urandom_range(0, 1)));
         else
            push(OP_CLEAR, rand_elem(0), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int dims [8] = '{1, 2, 3, 4, 5, 8, 16, 6};
      cycles = 0;
      sent = 0;
      burst = 0;
      dim = DIM_RESET;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_addr = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty table, extremes, tie, zero vector, wrong lengths, op switch
      push(OP_CLEAR, 16'sh7FFF, 1);
      write_reg(REG_EMBED_DIM, 4);
      send_vector(OP_QUERY, 4, 0);
      push(OP_LOAD, 16'sh7FFF, 0);
      push(OP_LOAD, 16'sh8000, 0);
      push(OP_LOAD, 16'sh0000, 0);
      push(OP_LOAD, 16'sh0001, 1);
      send_vector(OP_LOAD, 4, 3);
      push(OP_LOAD, 16'sh7FFF, 0);
      push(OP_LOAD, 16'sh8000, 0);
      push(OP_LOAD, 16'sh0000, 0);
      push(OP_LOAD, 16'sh0001, 1);
      send_vector(OP_QUERY, 4, 1);
      send_vector(OP_QUERY, 4, 3);
      send_vector(OP_LOAD, 2, 0);
      send_vector(OP_LOAD, 5, 0);
      push(OP_RSVD, 16'sh1234, 1);
      push(OP_LOAD, 16'sh4000, 0);
      send_vector(OP_QUERY, 4, 0);

      write_reg(REG_USE_THRESHOLD, 0);
      random_phase(80, 45);
      write_reg(REG_USE_THRESHOLD, 1);
      write_reg(REG_MAX_DISTANCE, 0);
      random_phase(60, 45);
      write_reg(REG_MAX_DISTANCE, 131072);
      random_phase(60, 45);
      write_reg(REG_MAX_DISTANCE, 262143);
      write_reg(REG_EMBED_DIM, 0);
      random_phase(20, 45);
      write_reg(REG_EMBED_DIM, 1023);
      random_phase(20, 45);
      write_reg(REG_EMBED_DIM, 1);
      write_reg(REG_USE_THRESHOLD, 0);
      // fill the table and push one row past it
      for (int r = 0; r <= MAX_ROWS; r++) send_vector(OP_LOAD, 1, $urandom_range(0, 4));
      random_phase(30, 80);
      write_reg(REG_USE_THRESHOLD, 1);
      for (int p = 0; p < 3; p++) begin
         write_reg(REG_EMBED_DIM, dims[$urandom_range(0, 7)]);
         write_reg(REG_USE_THRESHOLD, $urandom_range(0, 1));
         write_reg(REG_MAX_DISTANCE, $urandom_range(0, 140000));
         random_phase(50, 50);
         drain();
         random_phase(30, 50);
      end
      write_reg(REG_EMBED_DIM, 512);
      send_vector(OP_LOAD, 512, 0);
      write_reg(REG_EMBED_DIM, 3);
      random_phase(60, 50);
      drain();

      $display("sent %0d input transfers, checked %0d results", sent, checked);
      $display("embed_dim 0, 1..16, 512 and above range, full table, thresholds on/off");
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
